/* sv/nearest_segment_distance_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the nearest segment distance block
// Immediate-implication and next-cycle-implication property wrappers that
// sample on clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_SEGMENT_DISTANCE_TOP_MACROS_SVH
`define NEAREST_SEGMENT_DISTANCE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NSD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NSD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/nsd_pkg.sv */
// ----------------------------------------------------------------------------
// Nearest segment distance package
// Shared constants, controller states and the command and status structs.
// ----------------------------------------------------------------------------
package nsd_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned SEG_INDEX_WIDTH_DEF = 16;
  localparam int unsigned DIST_W = 33;
  localparam int unsigned OUT_SEG_W = 16;
  localparam int unsigned SHORT_W = 16;
  localparam int unsigned TOL_W = 2 * SHORT_W;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned OUT_TDATA_W = ((DIST_W + OUT_SEG_W + 7) / 8) * 8;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic {
    REG_SHORT_LENGTH = 1'b0
  } nsd_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_PREP,
    ST_PART,
    ST_COMB,
    ST_DIV,
    ST_UPD,
    ST_EMIT
  } nsd_state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic prep;
    logic part;
    logic comb;
    logic div_step;
    logic upd;
    logic emit;
  } nsd_cmd_t;

  typedef struct packed {
    logic proj;
    logic last;
    logic out_free;
  } nsd_status_t;

endpackage

/* sv/nearest_segment_distance_top.sv */
// ----------------------------------------------------------------------------
// Nearest segment distance top level
// Finds the segment nearest to a query point by squared distance.
// ----------------------------------------------------------------------------
// The input stream carries one segment per request, together with the query
// point; tlast marks the final segment of a point's run. The output stream
// carries one result per run: the smallest squared distance and the index of
// the first segment that reached it. short_length is set over the APB port.
// A segment is accepted only while the block is idle. A segment whose point
// projects onto it and that is longer than short_length goes through the
// serial divider of the squared cross term by the squared length, which
// yields one quotient bit per cycle; the other segments skip it. The final
// segment of a run also passes an emit state that moves the result into the
// output register. If that register still holds an untaken result, the
// block waits there until the receiver takes it. Reset clears the running
// minimum to all ones, the index to zero, short_length to zero and empties
// the output register.
// ----------------------------------------------------------------------------
module nearest_segment_distance_top
  import nsd_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned SEGMENT_INDEX_WIDTH = SEG_INDEX_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // point_x, point_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
  // segment_number
  input  logic [((6*COORD_WIDTH+SEGMENT_INDEX_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // min_dist_sq, nearest_segment
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic pready
);

  localparam int unsigned IN_TDATA_W = ((6*COORD_WIDTH+SEGMENT_INDEX_WIDTH+7)/8)*8;

  logic [SHORT_W-1:0] short_length_q;
  nsd_cmd_t cmd;
  nsd_status_t st;
  nsd_reg_e reg_sel;

  assign reg_sel = nsd_reg_e'(paddr[APB_AW-1]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_length_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_SHORT_LENGTH: short_length_q <= pwdata[SHORT_W-1:0];
        default: short_length_q <= short_length_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SHORT_LENGTH: prdata = APB_DW'(short_length_q);
      default: prdata = '0;
    endcase
  end

  nsd_ctrl #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  nsd_datapath #(
    .COORD_WIDTH         (COORD_WIDTH),
    .SEGMENT_INDEX_WIDTH (SEGMENT_INDEX_WIDTH),
    .IN_TDATA_W          (IN_TDATA_W)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .in_data_i      (s_axis_tdata),
    .in_last_i      (s_axis_tlast),
    .short_length_i (short_length_q),
    .m_tready_i     (m_axis_tready),
    .m_tvalid_o     (m_axis_tvalid),
    .m_tdata_o      (m_axis_tdata)
  );

endmodule

/* sv/nsd_datapath.sv */
// ----------------------------------------------------------------------------
// Nearest segment distance datapath
// Differences, products, sums, the squared cross term, a restoring divider,
// the running minimum and the output register.
// ----------------------------------------------------------------------------
module nsd_datapath
  import nsd_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned SEGMENT_INDEX_WIDTH = SEG_INDEX_WIDTH_DEF,
  parameter int unsigned IN_TDATA_W = ((6 * COORD_WIDTH + SEGMENT_INDEX_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  nsd_cmd_t               cmd_i,
  output nsd_status_t            st_o,
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  input  logic                   in_last_i,
  input  logic [SHORT_W-1:0]     short_length_i,
  input  logic                   m_tready_i,
  output logic                   m_tvalid_o,
  output logic [OUT_TDATA_W-1:0] m_tdata_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned SI = SEGMENT_INDEX_WIDTH;
  localparam int unsigned DF = W + 1;
  localparam int unsigned PW = 2 * W + 1;
  localparam int unsigned DW = 2 * W + 1;
  localparam int unsigned SW = 2 * W + 2;
  localparam int unsigned CW = 2 * W + 1;
  localparam int unsigned H  = W + 1;
  localparam int unsigned NW = 4 * W + 2;
  localparam int unsigned Q  = DW;
  localparam int unsigned XL = (DW > TOL_W) ? DW : TOL_W;
  localparam int unsigned XD = (DW > DIST_W) ? DW : DIST_W;
  localparam int unsigned XS = (SI > OUT_SEG_W) ? SI : OUT_SEG_W;

  logic [W-1:0] px, py, x0, y0, x1, y1;
  logic signed [DF-1:0] ax_d, ay_d, bx_d, by_d, dx_d, dy_d;
  logic signed [DF-1:0] ax_q, ay_q, bx_q, by_q, dx_q, dy_q;
  logic [SI-1:0] seg_q, best_seg_q, best_seg_d;
  logic last_q;

  logic signed [PW-1:0] axax_q, ayay_q, bxbx_q, byby_q, dxdx_q, dydy_q;
  logic signed [PW-1:0] axdx_q, aydy_q, aydx_q, axdy_q;
  logic [TOL_W-1:0] tol_q;

  logic [DW-1:0] d0_q, d1_q, len_q;
  logic signed [SW-1:0] dot_q, cross_q, cross_neg;

  logic [DW-1:0] dist_q;
  logic proj_q;
  logic [CW-1:0] c_q;

  logic [2*H-1:0] lolo_q;
  logic [W+H-1:0] hilo_q;
  logic [2*W-1:0] hihi_q;
  logic [NW-1:0] sq_sum;

  logic [DW-1:0] rem_q, rem_d;
  logic [Q-1:0] low_q, low_d;
  logic [DW:0] trial, diff;
  logic ge;

  logic [DW-1:0] cand;
  logic [XD-1:0] cand_x;
  logic [DIST_W-1:0] cand_sat;
  logic [DIST_W-1:0] best_dist_q, best_dist_d;
  logic [XS-1:0] best_seg_x;

  logic out_valid_q;
  logic [DIST_W-1:0] out_dist_q;
  logic [OUT_SEG_W-1:0] out_seg_q;

  assign px = in_data_i[0*W +: W];
  assign py = in_data_i[1*W +: W];
  assign x0 = in_data_i[2*W +: W];
  assign y0 = in_data_i[3*W +: W];
  assign x1 = in_data_i[4*W +: W];
  assign y1 = in_data_i[5*W +: W];

  assign ax_d = signed'({px[W-1], px}) - signed'({x0[W-1], x0});
  assign ay_d = signed'({py[W-1], py}) - signed'({y0[W-1], y0});
  assign bx_d = signed'({px[W-1], px}) - signed'({x1[W-1], x1});
  assign by_d = signed'({py[W-1], py}) - signed'({y1[W-1], y1});
  assign dx_d = signed'({x1[W-1], x1}) - signed'({x0[W-1], x0});
  assign dy_d = signed'({y1[W-1], y1}) - signed'({y0[W-1], y0});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q   <= ax_d;
      ay_q   <= ay_d;
      bx_q   <= bx_d;
      by_q   <= by_d;
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      seg_q  <= in_data_i[6*W +: SI];
      last_q <= in_last_i;
    end
    if (cmd_i.mul) begin
      axax_q <= PW'(ax_q) * PW'(ax_q);
      ayay_q <= PW'(ay_q) * PW'(ay_q);
      bxbx_q <= PW'(bx_q) * PW'(bx_q);
      byby_q <= PW'(by_q) * PW'(by_q);
      dxdx_q <= PW'(dx_q) * PW'(dx_q);
      dydy_q <= PW'(dy_q) * PW'(dy_q);
      axdx_q <= PW'(ax_q) * PW'(dx_q);
      aydy_q <= PW'(ay_q) * PW'(dy_q);
      aydx_q <= PW'(ay_q) * PW'(dx_q);
      axdy_q <= PW'(ax_q) * PW'(dy_q);
      tol_q  <= TOL_W'(short_length_i) * TOL_W'(short_length_i);
    end
    if (cmd_i.sum) begin
      d0_q    <= DW'($unsigned(axax_q)) + DW'($unsigned(ayay_q));
      d1_q    <= DW'($unsigned(bxbx_q)) + DW'($unsigned(byby_q));
      len_q   <= DW'($unsigned(dxdx_q)) + DW'($unsigned(dydy_q));
      dot_q   <= SW'(axdx_q) + SW'(aydy_q);
      cross_q <= SW'(aydx_q) - SW'(axdy_q);
    end
    if (cmd_i.prep) begin
      dist_q <= (d0_q < d1_q) ? d0_q : d1_q;
      proj_q <= (XL'(len_q) > XL'(tol_q)) && !dot_q[SW-1]
                && (signed'({1'b0, len_q}) >= dot_q);
      c_q    <= cross_q[SW-1] ? cross_neg[CW-1:0] : cross_q[CW-1:0];
    end
    if (cmd_i.part) begin
      lolo_q <= (2*H)'(c_q[H-1:0]) * (2*H)'(c_q[H-1:0]);
      hilo_q <= (W+H)'(c_q[CW-1:H]) * (W+H)'(c_q[H-1:0]);
      hihi_q <= (2*W)'(c_q[CW-1:H]) * (2*W)'(c_q[CW-1:H]);
    end
    if (cmd_i.comb) begin
      rem_q <= sq_sum[NW-1:Q];
      low_q <= sq_sum[Q-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  assign cross_neg = -cross_q;

  assign sq_sum = (NW'(hihi_q) << (2 * H)) + (NW'(hilo_q) << (H + 1)) + NW'(lolo_q);

  assign trial = {rem_q, low_q[Q-1]};
  assign diff  = trial - {1'b0, len_q};
  assign ge    = (trial >= {1'b0, len_q});
  assign rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
  assign low_d = {low_q[Q-2:0], ge};

  assign cand     = (proj_q && (low_q < dist_q)) ? low_q : dist_q;
  assign cand_x   = XD'(cand);
  assign cand_sat = (cand_x > XD'(DIST_MAX)) ? DIST_MAX : cand_x[DIST_W-1:0];

  always_comb begin
    best_dist_d = best_dist_q;
    best_seg_d  = best_seg_q;
    if (cmd_i.upd && (cand_sat < best_dist_q)) begin
      best_dist_d = cand_sat;
      best_seg_d  = seg_q;
    end else if (cmd_i.emit) begin
      best_dist_d = DIST_MAX;
      best_seg_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_dist_q <= DIST_MAX;
      best_seg_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      best_dist_q <= best_dist_d;
      best_seg_q  <= best_seg_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign best_seg_x = XS'(best_seg_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_dist_q <= best_dist_q;
      out_seg_q  <= best_seg_x[OUT_SEG_W-1:0];
    end
  end

  assign st_o.proj     = proj_q;
  assign st_o.last     = last_q;
  assign st_o.out_free = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = OUT_TDATA_W'({out_seg_q, out_dist_q});

endmodule

/* sv/nsd_ctrl.sv */
// ----------------------------------------------------------------------------
// Nearest segment distance controller
// Sequences one segment through the datapath and counts divider steps.
// ----------------------------------------------------------------------------
module nsd_ctrl
  import nsd_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  nsd_status_t st_i,
  output nsd_cmd_t    cmd_o
);

  localparam int unsigned Q = 2 * COORD_WIDTH + 1;
  localparam int unsigned CNTW = $clog2(Q);
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(Q - 1);

  nsd_state_e state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_MUL;
      ST_MUL:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_PREP;
      ST_PREP: state_d = ST_PART;
      ST_PART: begin
        state_d = st_i.proj ? ST_COMB : ST_UPD;
      end
      ST_COMB: state_d = ST_DIV;
      ST_DIV:  if (cnt_q == '0) state_d = ST_UPD;
      ST_UPD: begin
        state_d = st_i.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: if (st_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cnt_d      = cnt_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_MUL:  cmd_o.mul = 1'b1;
      ST_SUM:  cmd_o.sum = 1'b1;
      ST_PREP: cmd_o.prep = 1'b1;
      ST_PART: cmd_o.part = 1'b1;
      ST_COMB: begin
        cmd_o.comb = 1'b1;
        cnt_d      = CNT_LAST;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
      end
      ST_UPD:  cmd_o.upd = 1'b1;
      ST_EMIT: cmd_o.emit = st_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

/* sv/nsd_chk.sv */
// ----------------------------------------------------------------------------
// Nearest segment distance port checker
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`include "nearest_segment_distance_top_macros.svh"

module nsd_chk
  import nsd_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   psel,
  input logic                   penable,
  input logic                   pwrite,
  input logic [APB_AW-1:0]      paddr,
  input logic [APB_DW-1:0]      pwdata,
  input logic [APB_DW-1:0]      prdata,
  input logic                   pready
);

  logic in_acc;
  logic [DIST_W-1:0] res_dist;
  logic [OUT_SEG_W-1:0] res_seg;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign res_dist = m_axis_tdata[DIST_W-1:0];
  assign res_seg  = m_axis_tdata[DIST_W +: OUT_SEG_W];

  `NSD_ASSERT_NXT(a_busy_after_accept, in_acc, !s_axis_tready,
    "block took a second segment while still working")

  `NSD_ASSERT_NXT(a_no_result_mid_run, in_acc && !s_axis_tlast && !m_axis_tvalid,
    !m_axis_tvalid, "result appeared after a segment that was not the last")

  `NSD_ASSERT_IMP(a_empty_run_index, m_axis_tvalid && (res_dist == DIST_MAX),
    res_seg == '0, "run without improvement reported a nonzero index")

  `NSD_ASSERT_NXT(a_result_holds, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed or vanished")

  `NSD_ASSERT_NXT(a_cfg_readback,
    psel && penable && pwrite && pready && (paddr[APB_AW-1] == REG_SHORT_LENGTH),
    (paddr[APB_AW-1] != REG_SHORT_LENGTH) || (prdata[SHORT_W-1:0] == $past(pwdata[SHORT_W-1:0])),
    "short_length read back differs from the value written")

endmodule

bind nearest_segment_distance_top nsd_chk u_nsd_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);
